FILE: hdl/gcd_pkg.sv
// ----------------------------------------------------------------------------
// Great-circle distance package
// Widths, fixed-point constants and the arctangent table that the datapath
// modules share.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int DW = 34;
  localparam int UW = 26;
  localparam int RW = 24;
  localparam int OW = 26;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int MAX_STEPS = 32;

  localparam logic [RW-1:0] RADIUS_RST = 24'd6371000;
  localparam logic [29:0] GAIN_INV_Q30 = 30'd652032874;
  localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
  localparam logic signed [26:0] FULL_TURN = 27'sd47185920;
  localparam logic signed [26:0] HALF_TURN = 27'sd23592960;
  localparam logic signed [26:0] QUARTER_TURN = 27'sd11796480;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic [OW-1:0] DIST_MAX = 26'h3FFFFFF;

  localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
    32'h00000000, 32'h00000000
  };

endpackage

FILE: hdl/gcd_angle_prep.sv
// ----------------------------------------------------------------------------
// Angle preparation
// Reduces an angle to within plus or minus a half turn, folds it to within plus
// or minus a quarter turn and converts it to radians in two register stages.
// ----------------------------------------------------------------------------
module gcd_angle_prep
  import gcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [UW-1:0] in_u,
  output logic                 out_vld,
  output logic signed [DW-1:0] out_z,
  output logic                 out_flip
);

  logic signed [26:0] u_ext;
  logic signed [26:0] r_wrap;
  logic signed [26:0] r_fold;
  logic               flip_nxt;
  logic [23:0]        mag_nxt;

  logic               v1_r;
  logic [23:0]        mag_r;
  logic               neg_r;
  logic               flip1_r;

  logic [50:0]        prod;
  logic [DW-1:0]      zmag;

  logic               v2_r;
  logic signed [DW-1:0] z_r;
  logic               flip2_r;

  assign u_ext = 27'(in_u);

  always_comb begin
    if (u_ext >= HALF_TURN) begin
      r_wrap = u_ext - FULL_TURN;
    end else if (u_ext < -HALF_TURN) begin
      r_wrap = u_ext + FULL_TURN;
    end else begin
      r_wrap = u_ext;
    end
    if (r_wrap > QUARTER_TURN) begin
      r_fold   = HALF_TURN - r_wrap;
      flip_nxt = 1'b1;
    end else if (r_wrap < -QUARTER_TURN) begin
      r_fold   = -HALF_TURN - r_wrap;
      flip_nxt = 1'b1;
    end else begin
      r_fold   = r_wrap;
      flip_nxt = 1'b0;
    end
    mag_nxt = r_fold[26] ? 24'(-r_fold) : r_fold[23:0];
  end

  assign prod = 51'(mag_r) * 51'(DEG2RAD_Q32);
  assign zmag = DW'(prod[50:19]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    neg_r   <= r_fold[26];
    flip1_r <= flip_nxt;
    z_r     <= neg_r ? -$signed(zmag) : $signed(zmag);
    flip2_r <= flip1_r;
  end

  assign out_vld  = v2_r;
  assign out_z    = z_r;
  assign out_flip = flip2_r;

endmodule

FILE: hdl/gcd_cordic_rot.sv
// ----------------------------------------------------------------------------
// Rotation CORDIC
// One register stage per iteration, then a stage that applies the cosine
// sign from the quadrant fold.
// ----------------------------------------------------------------------------
module gcd_cordic_rot
  import gcd_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [DW-1:0] in_z,
  input  logic                 in_flip,
  output logic                 out_vld,
  output logic signed [DW-1:0] out_sin,
  output logic signed [DW-1:0] out_cos
);

  logic                 v_r [STEPS];
  logic                 f_r [STEPS];
  logic signed [DW-1:0] x_r [STEPS];
  logic signed [DW-1:0] y_r [STEPS];
  logic signed [DW-1:0] z_r [STEPS];

  logic                 vo_r;
  logic signed [DW-1:0] sin_r;
  logic signed [DW-1:0] cos_r;

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic                 vp;
    logic                 fp;
    logic signed [DW-1:0] xp;
    logic signed [DW-1:0] yp;
    logic signed [DW-1:0] zp;
    logic signed [DW-1:0] at;

    if (i == 0) begin : g_first
      assign vp = in_vld;
      assign fp = in_flip;
      assign xp = $signed(DW'(GAIN_INV_Q30));
      assign yp = '0;
      assign zp = in_z;
    end else begin : g_next
      assign vp = v_r[i-1];
      assign fp = f_r[i-1];
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
    end

    assign at = $signed(DW'(ATAN_TAB[i]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      f_r[i] <= fp;
      if (zp >= 0) begin
        x_r[i] <= xp - (yp >>> i);
        y_r[i] <= yp + (xp >>> i);
        z_r[i] <= zp - at;
      end else begin
        x_r[i] <= xp + (yp >>> i);
        y_r[i] <= yp - (xp >>> i);
        z_r[i] <= zp + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    sin_r <= y_r[STEPS-1];
    cos_r <= f_r[STEPS-1] ? -x_r[STEPS-1] : x_r[STEPS-1];
  end

  assign out_vld = vo_r;
  assign out_sin = sin_r;
  assign out_cos = cos_r;

endmodule

FILE: hdl/gcd_sqrt.sv
// ----------------------------------------------------------------------------
// Square root pipeline
// Digit recurrence for the floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module gcd_sqrt
  import gcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [60:0] in_val,
  output logic        out_vld,
  output logic [30:0] out_root
);

  localparam int NB = 32;

  logic        v_r [NB];
  logic [63:0] rem_r [NB];
  logic [63:0] root_r [NB];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic        vp;
    logic [63:0] remp;
    logic [63:0] rootp;
    logic [63:0] trial;

    if (k == 0) begin : g_first
      assign vp    = in_vld;
      assign remp  = 64'(in_val);
      assign rootp = '0;
    end else begin : g_next
      assign vp    = v_r[k-1];
      assign remp  = rem_r[k-1];
      assign rootp = root_r[k-1];
    end

    assign trial = rootp + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (remp >= trial) begin
        rem_r[k]  <= remp - trial;
        root_r[k] <= (rootp >> 1) + BIT;
      end else begin
        rem_r[k]  <= remp;
        root_r[k] <= rootp >> 1;
      end
    end
  end

  assign out_vld  = v_r[NB-1];
  assign out_root = root_r[NB-1][30:0];

endmodule

FILE: hdl/gcd_cordic_vec.sv
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// Turns the two root values into half the central angle, one register stage
// per iteration.
// ----------------------------------------------------------------------------
module gcd_cordic_vec
  import gcd_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [30:0]          in_x,
  input  logic [30:0]          in_y,
  output logic                 out_vld,
  output logic signed [DW-1:0] out_z
);

  logic                 v_r [STEPS];
  logic signed [DW-1:0] x_r [STEPS];
  logic signed [DW-1:0] y_r [STEPS];
  logic signed [DW-1:0] z_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic                 vp;
    logic signed [DW-1:0] xp;
    logic signed [DW-1:0] yp;
    logic signed [DW-1:0] zp;
    logic signed [DW-1:0] at;

    if (i == 0) begin : g_first
      assign vp = in_vld;
      assign xp = $signed(DW'(in_x));
      assign yp = $signed(DW'(in_y));
      assign zp = '0;
    end else begin : g_next
      assign vp = v_r[i-1];
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
    end

    assign at = $signed(DW'(ATAN_TAB[i]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (yp > 0) begin
        x_r[i] <= xp + (yp >>> i);
        y_r[i] <= yp - (xp >>> i);
        z_r[i] <= zp + at;
      end else begin
        x_r[i] <= xp - (yp >>> i);
        y_r[i] <= yp + (xp >>> i);
        z_r[i] <= zp - at;
      end
    end
  end

  assign out_vld = v_r[STEPS-1];
  assign out_z   = z_r[STEPS-1];

endmodule

FILE: hdl/great_circle_distance.sv
// ----------------------------------------------------------------------------
// Great-circle distance
// Haversine distance between two points, fully pipelined.
// Pipeline depth is set by the two CORDIC chains and the 32-stage square root
// pipeline.
// Throughput is one word per cycle; busy stays low and the receiver cannot
// stall. Synchronous active-low reset clears all valid bits and sets the
// radius to 6371000 m.
// ----------------------------------------------------------------------------
module great_circle_distance
  import gcd_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [23:0]   in_lat_a,
  input  logic signed [24:0]   in_lon_a,
  input  logic signed [23:0]   in_lat_b,
  input  logic signed [24:0]   in_lon_b,
  input  logic                 cfg_wr_en,
  input  logic [RW-1:0]        cfg_wr_data,
  output logic                 out_valid,
  output logic [OW-1:0]        out_distance_m
);

  localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

  logic [RW-1:0]        radius_r;

  logic                 in_vld_r;
  logic signed [UW-1:0] u_r [4];

  logic                 prep_vld [4];
  logic signed [DW-1:0] prep_z [4];
  logic                 prep_flip [4];
  logic                 rot_vld [4];
  logic signed [DW-1:0] rot_sin [4];
  logic signed [DW-1:0] rot_cos [4];

  logic signed [63:0]   sq1;
  logic signed [63:0]   sq2;
  logic signed [63:0]   cc;
  logic                 p1_vld_r;
  logic signed [DW-1:0] s1sq_r;
  logic signed [DW-1:0] s2sq_r;
  logic signed [DW-1:0] p_r;

  logic signed [67:0]   tprod;
  logic                 p2_vld_r;
  logic signed [DW-1:0] s1sq2_r;
  logic signed [DW-1:0] t_r;

  logic signed [DW:0]   a_sum;
  logic [30:0]          a_nxt;
  logic                 a_vld_r;
  logic [30:0]          a_r;

  logic                 sa_vld;
  logic                 sb_vld;
  logic [30:0]          root_a;
  logic [30:0]          root_b;

  logic                 vec_vld;
  logic signed [DW-1:0] vec_z;

  logic [31:0]          z_clamp;
  logic                 f1_vld_r;
  logic [55:0]          dprod_r;
  logic [56:0]          dsum;
  logic [27:0]          dscaled;
  logic                 out_valid_r;
  logic [OW-1:0]        dist_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    u_r[0] <= UW'(in_lat_b) - UW'(in_lat_a);
    u_r[1] <= UW'(in_lon_b) - UW'(in_lon_a);
    u_r[2] <= UW'(in_lat_a) <<< 1;
    u_r[3] <= UW'(in_lat_b) <<< 1;
  end

  for (genvar k = 0; k < 4; k++) begin : g_angle
    gcd_angle_prep u_prep (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (in_vld_r),
      .in_u     (u_r[k]),
      .out_vld  (prep_vld[k]),
      .out_z    (prep_z[k]),
      .out_flip (prep_flip[k])
    );

    gcd_cordic_rot #(
      .STEPS (STEPS)
    ) u_rot (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (prep_vld[k]),
      .in_z    (prep_z[k]),
      .in_flip (prep_flip[k]),
      .out_vld (rot_vld[k]),
      .out_sin (rot_sin[k]),
      .out_cos (rot_cos[k])
    );
  end

  assign sq1 = $signed(rot_sin[0][31:0]) * $signed(rot_sin[0][31:0]);
  assign sq2 = $signed(rot_sin[1][31:0]) * $signed(rot_sin[1][31:0]);
  assign cc  = $signed(rot_cos[2][31:0]) * $signed(rot_cos[3][31:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      a_vld_r  <= 1'b0;
    end else begin
      p1_vld_r <= rot_vld[0];
      p2_vld_r <= p1_vld_r;
      a_vld_r  <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1sq_r <= sq1[63:30];
    s2sq_r <= sq2[63:30];
    p_r    <= cc[63:30];
  end

  assign tprod = 68'(s2sq_r) * 68'(p_r);

  always_ff @(posedge clk) begin
    s1sq2_r <= s1sq_r;
    t_r     <= tprod[63:30];
  end

  assign a_sum = (DW + 1)'(s1sq2_r) + (DW + 1)'(t_r);

  always_comb begin
    if (a_sum < 0) begin
      a_nxt = '0;
    end else if (a_sum > $signed((DW + 1)'(ONE_Q30))) begin
      a_nxt = ONE_Q30;
    end else begin
      a_nxt = a_sum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
  end

  gcd_sqrt u_sqrt_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (a_vld_r),
    .in_val   ({a_r, 30'd0}),
    .out_vld  (sa_vld),
    .out_root (root_a)
  );

  gcd_sqrt u_sqrt_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (a_vld_r),
    .in_val   ({ONE_Q30 - a_r, 30'd0}),
    .out_vld  (sb_vld),
    .out_root (root_b)
  );

  gcd_cordic_vec #(
    .STEPS (STEPS)
  ) u_vec (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sa_vld),
    .in_x    (root_b),
    .in_y    (root_a),
    .out_vld (vec_vld),
    .out_z   (vec_z)
  );

  assign z_clamp = vec_z[DW-1] ? 32'd0 : vec_z[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      f1_vld_r    <= vec_vld;
      out_valid_r <= f1_vld_r;
    end
  end

  assign dsum    = 57'(dprod_r) + (57'd1 << 28);
  assign dscaled = dsum[56:29];

  always_ff @(posedge clk) begin
    dprod_r <= 56'(radius_r) * 56'(z_clamp);
    dist_r  <= (dscaled > 28'(DIST_MAX)) ? DIST_MAX : dscaled[OW-1:0];
  end

  assign out_valid      = out_valid_r;
  assign out_distance_m = dist_r;

`ifndef SYNTHESIS
  a_busy_low : assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised although the pipeline never stalls");

  a_hav_clamped : assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r |-> (a_r <= ONE_Q30))
    else $error("haversine term exceeds one");

  a_roots_aligned : assert property (@(posedge clk) disable iff (!rst_n)
    sa_vld == sb_vld)
    else $error("square root pipelines out of step");

  a_out_follows : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(f1_vld_r))
    else $error("result strobe without a word in the final stage");
`endif

endmodule

FILE: sim/great_circle_distance_test.sv
// ----------------------------------------------------------------------------
// Great-circle distance testbench
// Drives coordinate words into the haversine pipeline under several idling
// phases and radius settings, predicts each distance with a bit-exact
// fixed-point model and compares every output word in order.
// ----------------------------------------------------------------------------
module great_circle_distance_test;
  import gcd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 24;
  localparam int LATENCY = 2 * STEPS + 41;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_WORDS = 1900;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [23:0] in_lat_a;
  logic signed [24:0] in_lon_a;
  logic signed [23:0] in_lat_b;
  logic signed [24:0] in_lon_b;
  logic cfg_wr_en;
  logic [RW-1:0] cfg_wr_data;
  logic out_valid;
  logic [OW-1:0] out_distance_m;

  typedef struct {
    logic signed [23:0] lat_a;
    logic signed [24:0] lon_a;
    logic signed [23:0] lat_b;
    logic signed [24:0] lon_b;
    bit known;
    logic [OW-1:0] distance;
  } route_t;

  logic [RW-1:0] radius_m;
  logic [OW-1:0] pending_distances[$];
  int errors;
  int words_sent;
  int words_checked;
  int idle_cycles;
  int sender_idle_pct;

  great_circle_distance #(.CORDIC_STEPS(STEPS)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_lat_a(in_lat_a),
    .in_lon_a(in_lon_a),
    .in_lat_b(in_lat_b),
    .in_lon_b(in_lon_b),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid),
    .out_distance_m(out_distance_m)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -64'sd1 - ((-64'sd1 - v) >>> s);
  endfunction

  function automatic void rotate_angle(longint u, output longint s, output longint c);
    longint r, mag, z, x, y, dx, dy;
    bit flip;
    flip = 0;
    r = u % 47185920;
    if (r < 0) r += 47185920;
    if (r >= 23592960) r -= 47185920;
    if (r > 11796480) begin
      r = 23592960 - r;
      flip = 1;
    end else if (r < -11796480) begin
      r = -23592960 - r;
      flip = 1;
    end
    mag = (r < 0) ? -r : r;
    z = (mag * 74961321) >>> 19;
    if (r < 0) z = -z;
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_TAB[i]);
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic longint floor_root(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic logic [OW-1:0] haversine_distance(route_t w, logic [RW-1:0] radius);
    longint s1, s2, c1, c2, dummy, s1sq, s2sq, p, a, x, y, z, dx, dy;
    longint unsigned d;
    rotate_angle(longint'(w.lat_b) - longint'(w.lat_a), s1, dummy);
    rotate_angle(longint'(w.lon_b) - longint'(w.lon_a), s2, dummy);
    rotate_angle(2 * longint'(w.lat_a), dummy, c1);
    rotate_angle(2 * longint'(w.lat_b), dummy, c2);
    s1sq = (s1 * s1) >>> 30;
    s2sq = (s2 * s2) >>> 30;
    p = floor_shift(c1 * c2, 30);
    a = s1sq + floor_shift(s2sq * p, 30);
    if (a < 0) a = 0;
    if (a > 1073741824) a = 1073741824;
    y = floor_root(longint'(a) << 30);
    x = floor_root(longint'(1073741824 - a) << 30);
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_TAB[i]);
      end
    end
    if (z < 0) z = 0;
    d = (longint'(radius) * z + (64'd1 << 28)) >> 29;
    if (d > 67108863) d = 67108863;
    return d[OW-1:0];
  endfunction

  task automatic send_route(route_t w);
    logic [OW-1:0] expected;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    in_lat_a <= w.lat_a;
    in_lon_a <= w.lon_a;
    in_lat_b <= w.lat_b;
    in_lon_b <= w.lon_b;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected = w.known ? w.distance : haversine_distance(w, radius_m);
    pending_distances = {pending_distances, expected};
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_distances.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_radius(logic [RW-1:0] r);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= r;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    radius_m = r;
  endtask

  function automatic route_t random_route();
    route_t w;
    w.known = 0;
    w.distance = '0;
    case ($urandom_range(9))
      0: begin
        w.lat_a = 24'($urandom);
        w.lon_a = 25'($urandom);
        w.lat_b = 24'($urandom);
        w.lon_b = 25'($urandom);
      end
      1: begin
        w.lat_a = $signed(24'($urandom_range(11796480))) - 24'sd5898240;
        w.lon_a = $signed(25'($urandom_range(23592960))) - 25'sd11796480;
        w.lat_b = w.lat_a + $signed(24'($urandom_range(64))) - 24'sd32;
        w.lon_b = w.lon_a + $signed(25'($urandom_range(64))) - 25'sd32;
      end
      2: begin
        w.lat_a = $signed(24'($urandom_range(11796480))) - 24'sd5898240;
        w.lon_a = $signed(25'($urandom_range(23592960))) - 25'sd11796480;
        w.lat_b = -w.lat_a;
        w.lon_b = w.lon_a + (w.lon_a < 0 ? 25'sd11796480 : -25'sd11796480);
      end
      default: begin
        w.lat_a = $signed(24'($urandom_range(11796480))) - 24'sd5898240;
        w.lon_a = $signed(25'($urandom_range(23592960))) - 25'sd11796480;
        w.lat_b = $signed(24'($urandom_range(11796480))) - 24'sd5898240;
        w.lon_b = $signed(25'($urandom_range(23592960))) - 25'sd11796480;
      end
    endcase
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_distances.size() == 0) begin
        $error("distance_m: unexpected word, actual %0d", out_distance_m);
        errors++;
      end else begin
        if (out_distance_m !== pending_distances[0]) begin
          $error("distance_m: expected %0d, actual %0d", pending_distances[0],
                 out_distance_m);
          errors++;
        end
        void'(pending_distances.pop_front());
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("great_circle_distance_test: FAIL");
      $finish;
    end
  end

  route_t directed[16] = '{
    '{24'sd0, 25'sd0, 24'sd0, 25'sd0, 1'b0, 26'd0},
    '{24'sd5898240, 25'sd0, 24'sd5898240, 25'sd0, 1'b0, 26'd0},
    '{-24'sd5898240, 25'sd11796480, -24'sd5898240, -25'sd11796480, 1'b0, 26'd0},
    '{24'sd5898240, 25'sd0, -24'sd5898240, 25'sd0, 1'b0, 26'd0},
    '{24'sd0, 25'sd0, 24'sd0, 25'sd11796480, 1'b0, 26'd0},
    '{24'sd0, -25'sd11796480, 24'sd0, 25'sd11796480, 1'b0, 26'd0},
    '{24'sd0, 25'sd0, 24'sd0, 25'sd5898240, 1'b0, 26'd0},
    '{24'sd3342336, -25'sd5000000, -24'sd2000000, 25'sd9000000, 1'b0, 26'd0},
    '{24'sd1, 25'sd0, 24'sd0, 25'sd1, 1'b0, 26'd0},
    '{24'sh7FFFFF, 25'sh0FFFFFF, 24'sh800000, 25'sh1000000, 1'b0, 26'd0},
    '{24'sh800000, 25'sh1000000, 24'sh7FFFFF, 25'sh0FFFFFF, 1'b0, 26'd0},
    '{24'sh7FFFFF, 25'sh1000000, 24'sh7FFFFF, 25'sh1000000, 1'b0, 26'd0},
    '{24'sd7000000, 25'sd100, -24'sd7000000, 25'sd16000000, 1'b0, 26'd0},
    '{24'sd2949120, 25'sd0, 24'sd2949120, -25'sd11796480, 1'b0, 26'd0},
    '{-24'sd1, -25'sd1, 24'sd1, 25'sd1, 1'b0, 26'd0},
    '{24'sd5555555, 25'sh0AAAAAA, -24'sd5555555, -25'sh0555555, 1'b0, 26'd0}
  };

  logic [RW-1:0] radius_plan[5] = '{24'd1, 24'hFFFFFF, 24'd6371000, 24'd1000, 24'd12345678};
  int idle_plan[4] = '{0, 54, 31, 0};

  initial begin
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    idle_cycles = 0;
    sender_idle_pct = 0;
    radius_m = RADIUS_RST;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_lat_a = '0;
    in_lon_a = '0;
    in_lat_b = '0;
    in_lon_b = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_route(directed[i]);
    drain_pipeline();

    foreach (radius_plan[r]) begin
      write_radius(radius_plan[r]);
      foreach (directed[i]) begin
        route_t w;
        w = directed[i];
        w.known = 0;
        send_route(w);
      end
      for (int n = 0; n < RANDOM_WORDS / 5; n++) begin
        sender_idle_pct = idle_plan[(n / 95) % 4];
        send_route(random_route());
      end
      drain_pipeline();
    end

    $display("Sent %0d coordinate words over %0d radius settings; checked %0d distances.",
             words_sent, $size(radius_plan) + 1, words_checked);
    if (errors == 0) begin
      $display("great_circle_distance_test: PASS");
    end else begin
      $display("great_circle_distance_test: FAIL");
    end
    $finish;
  end

endmodule
